### hw/rtl/mmcs_pkg.sv
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared types and constants for the min-max contrast stretch core.
// ----------------------------------------------------------------------------
package mmcs_pkg;

    localparam int STAT_W          = 16;     // pixel, min, max and threshold width
    localparam int P_PIXEL_BITS    = 16;     // default significant pixel bits
    localparam int QUO_W           = 8;      // display pixel width, one bit per step
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_ADDR_W      = 3;

    localparam logic [STAT_W-1:0] THRESH_RESET = 16'd16384;
    localparam logic [QUO_W-1:0]  DISP_MAX     = 8'hFF;
    localparam logic [QUO_W-1:0]  DISP_ZERO    = 8'h00;

    // operation codes
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_MAP     = 1'b1;

    // register index of the outlier threshold
    localparam logic REG_THRESH = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic accept;    // input beat taken this cycle
        logic div_step;  // one restoring division step
        logic out_load;  // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic special;   // map beat resolved without division
        logic out_free;  // output register can take a result
    } t_dp_sts;

endpackage

### hw/rtl/mmcs_ctrl.sv
// ----------------------------------------------------------------------------
// mmcs_ctrl
// Sequencer: accepts beats, runs the divider steps and hands the result on.
// ----------------------------------------------------------------------------
module mmcs_ctrl
    import mmcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_operation,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam int CNT_W = $clog2(QUO_W);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_ready        = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                n_cnt        = '0;
                if (i_valid && (i_operation == OP_MAP)) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.special) begin
                    n_state = ST_WRITE;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(QUO_W - 1)) begin
                        n_state = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/mmcs_dp.sv
// ----------------------------------------------------------------------------
// mmcs_dp
// Datapath: range statistics, outlier tests, restoring divider, output stage.
// ----------------------------------------------------------------------------
module mmcs_dp
    import mmcs_pkg::*;
#(
    parameter int PIXEL_BITS = P_PIXEL_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [STAT_W-1:0] i_thresh,
    input  logic              i_operation,
    input  logic [STAT_W-1:0] i_pixel,
    input  logic              i_frame_start,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [QUO_W-1:0]  o_display_pixel,
    output logic              o_clipped
);

    localparam int DW = PIXEL_BITS + 1;
    localparam logic [STAT_W-1:0] PIX_MASK =
        STAT_W'((STAT_W+1)'(1) << PIXEL_BITS) - STAT_W'(1);

    logic [STAT_W-1:0] r_min, r_max;
    logic              r_any;
    logic [DW-1:0]     r_rem, r_div;
    logic [QUO_W-1:0]  r_quo;
    logic              r_special;
    logic [QUO_W-1:0]  r_spec_pix;
    logic              r_spec_clip;
    logic              r_out_valid;
    logic [QUO_W-1:0]  r_out_pix;
    logic              r_out_clip;

    logic [STAT_W-1:0] p;
    logic [STAT_W-1:0] base_min, base_max;
    logic              base_any;
    logic [STAT_W-1:0] n_min, n_max;
    logic              n_any;
    logic              map_special;
    logic [QUO_W-1:0]  map_pix;
    logic              map_clip;
    logic [DW:0]       rem_sh;
    logic              q_bit;
    logic [DW-1:0]     n_rem;

    assign p = STAT_W'(i_pixel[PIXEL_BITS-1:0]);

    // measure: frame start resets the range before this pixel counts
    always_comb begin
        base_min = i_frame_start ? PIX_MASK : r_min;
        base_max = i_frame_start ? '0 : r_max;
        base_any = i_frame_start ? 1'b0 : r_any;
        n_min    = base_min;
        n_max    = base_max;
        n_any    = base_any;
        if (p < i_thresh) begin
            n_any = 1'b1;
            if (!base_any) begin
                n_min = p;
                n_max = p;
            end else begin
                if (p > base_max) n_max = p;
                if (p < base_min) n_min = p;
            end
        end
    end

    // map: saturating and empty-range cases need no division
    always_comb begin
        map_special = 1'b1;
        map_pix     = DISP_ZERO;
        map_clip    = 1'b0;
        if (!r_any) begin
            map_pix = DISP_ZERO;
        end else if ((p >= i_thresh) || (p > r_max)) begin
            map_pix  = DISP_MAX;
            map_clip = 1'b1;
        end else if (p < r_min) begin
            map_pix  = DISP_ZERO;
            map_clip = 1'b1;
        end else begin
            map_special = 1'b0;
        end
    end

    // restoring step; remainder stays below the span so one subtract suffices
    assign rem_sh = {r_rem, 1'b0};
    assign q_bit  = (rem_sh >= {1'b0, r_div});
    always_comb begin
        if (q_bit) n_rem = DW'(rem_sh - {1'b0, r_div});
        else       n_rem = rem_sh[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= THRESH_RESET;
            r_max <= '0;
            r_any <= 1'b0;
        end else if (i_cmd.accept && (i_operation == OP_MEASURE)) begin
            r_min <= n_min;
            r_max <= n_max;
            r_any <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_operation == OP_MAP)) begin
            r_special   <= map_special;
            r_spec_pix  <= map_pix;
            r_spec_clip <= map_clip;
            r_rem       <= DW'(p[PIXEL_BITS-1:0] - r_min[PIXEL_BITS-1:0]);
            r_div       <= DW'({1'b0, r_max[PIXEL_BITS-1:0]})
                         - DW'({1'b0, r_min[PIXEL_BITS-1:0]}) + DW'(1);
            r_quo       <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QUO_W-2:0], q_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pix  <= r_special ? r_spec_pix : r_quo;
            r_out_clip <= r_special ? r_spec_clip : 1'b0;
        end
    end

    assign o_sts.special  = r_special;
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign o_valid         = r_out_valid;
    assign o_display_pixel = r_out_pix;
    assign o_clipped       = r_out_clip;

`ifndef SYNTHESIS
    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_div))
        else $error("divider remainder not below span");

    a_range_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (r_min <= r_max))
        else $error("measured min above max");

    a_clip_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clip) |-> ((r_out_pix == DISP_ZERO) || (r_out_pix == DISP_MAX)))
        else $error("clipped beat not saturated");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !i_cmd.out_load)
        else $error("held result overwritten");
`endif

endmodule

### hw/rtl/min_max_contrast_stretch_core.sv
// ----------------------------------------------------------------------------
// min_max_contrast_stretch_core
// 16-bit infrared pixel to 8-bit display pixel by min-max contrast stretch.
//
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-------------------------------
// input     | in        | i_valid / o_ready  | i_operation i_pixel i_frame_start
// output    | out       | o_valid / i_ready  | o_display_pixel o_clipped
// config    | in        | APB psel/penable   | paddr pwdata prdata
//
// A measure beat gives no result.
// A map beat is accepted, runs 8 restoring divider steps and is then written;
// a saturated or empty-range map beat skips the steps. The 8-bit quotient loop sets their number.
// The output register lets the next beat be accepted while a result waits.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch_core
    import mmcs_pkg::*;
#(
    parameter int PIXEL_BITS = P_PIXEL_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_operation,
    input  logic [STAT_W-1:0]     i_pixel,
    input  logic                  i_frame_start,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [QUO_W-1:0]      o_display_pixel,
    output logic                  o_clipped,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [STAT_W-1:0] r_thresh;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_THRESH)) begin
            r_thresh <= pwdata[STAT_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_THRESH: prdata = CFG_DATA_W'(r_thresh);
            default:    prdata = '0;
        endcase
    end

    mmcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mmcs_dp #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_thresh        (r_thresh),
        .i_operation     (i_operation),
        .i_pixel         (i_pixel),
        .i_frame_start   (i_frame_start),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_display_pixel (o_display_pixel),
        .o_clipped       (o_clipped)
    );

endmodule
